FILE: rtl/chol_pkg.sv
// Shared types, constants and helpers for the Cholesky factorization block.
`default_nettype none
package chol_pkg;

  localparam int IDX_W  = 3;
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int ROOT_W = 24;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_ACC,
    S_OPA,
    S_MUL,
    S_SUB,
    S_FIN,
    S_SQRT,
    S_DIV,
    S_WR,
    S_EM_RD,
    S_EM_LD
  } chol_state_t;

  typedef enum logic {
    SD_SQRT,
    SD_DIV
  } sd_op_t;

  typedef struct packed {
    logic   start;
    sd_op_t op;
  } sd_cmd_t;

  // Clamp a wide signed value into the Q16.16 range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      sat_val = VAL_W'(hi);
    end else if (x < lo) begin
      sat_val = VAL_W'(lo);
    end else begin
      sat_val = VAL_W'(x);
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/chol_store.sv
// Matrix store: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module chol_store
  import chol_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [VAL_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [VAL_W-1:0] mem_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vld_q <= vld[raddr];
    end
  end

  assign rdata = vld_q ? mem_q : '0;

endmodule
`default_nettype wire

FILE: rtl/chol_sqdiv.sv
// Bit-serial unit: Q16.16 square root (24 steps) or signed divide (48 steps).
`default_nettype none
module chol_sqdiv
  import chol_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire sd_cmd_t                 cmd,
  input  wire logic signed [VAL_W-1:0] opnd,
  input  wire logic [ROOT_W-1:0]       divisor,
  output logic                         busy,
  output logic                         done,
  output logic signed [VAL_W-1:0]      result
);

  logic [5:0]        cnt;
  sd_op_t            op;
  logic [47:0]       work;
  logic [27:0]       rem;
  logic [47:0]       q;
  logic              neg;
  logic [ROOT_W-1:0] dvs;
  logic [VAL_W-1:0]  mag;
  logic [27:0]       rs_sq;
  logic [27:0]       tr_sq;
  logic [27:0]       rs_dv;
  logic [27:0]       tr_dv;

  assign mag   = opnd[VAL_W-1] ? VAL_W'(-opnd) : opnd;
  assign rs_sq = {rem[25:0], work[47:46]};
  assign tr_sq = {2'b00, q[ROOT_W-1:0], 2'b01};
  assign rs_dv = {rem[26:0], work[47]};
  assign tr_dv = {4'b0000, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= (cmd.op == SD_SQRT) ? 6'd24 : 6'd48;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op   <= cmd.op;
      rem  <= '0;
      q    <= '0;
      dvs  <= divisor;
      neg  <= opnd[VAL_W-1];
      work <= (cmd.op == SD_SQRT) ? {opnd, 16'h0000} : {mag, 16'h0000};
    end else if (busy) begin
      if (op == SD_SQRT) begin
        work <= {work[45:0], 2'b00};
        if (rs_sq >= tr_sq) begin
          rem <= rs_sq - tr_sq;
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= rs_sq;
          q   <= {q[46:0], 1'b0};
        end
      end else begin
        work <= {work[46:0], 1'b0};
        if (rs_dv >= tr_dv) begin
          rem <= rs_dv - tr_dv;
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= rs_dv;
          q   <= {q[46:0], 1'b0};
        end
      end
    end
  end

  // sign and saturation of the quotient
  always_comb begin
    if (op == SD_SQRT) begin
      result = VAL_W'(q[ROOT_W-1:0]);
    end else if (neg) begin
      result = (q > 48'h0000_8000_0000) ? 32'sh8000_0000 : VAL_W'(-q);
    end else begin
      result = (q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : VAL_W'(q);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cholesky_factorization.sv
// Top level of the Cholesky factorization block: sequencer, arithmetic and ports.
`default_nettype none
// Loads a symmetric Q16.16 matrix one element per cycle (row, col, value); an
// element with last set starts an in-place lower Cholesky factorization of the
// leading order-by-order block, after which the factor is emitted in row-major
// order with zeros above the diagonal. Loads are not taken while a
// factorization or emission is running. All matrix data sits in a single
// one-read one-write store with a registered read port, so each
// multiply-accumulate of the inner product runs as operand read, multiply
// and subtract. Each diagonal costs a bit-serial square root (24 steps),
// each below-diagonal entry a bit-serial divide (48 steps). Each result
// is presented only after the previous one has been taken. A pivot that is
// zero or negative zeroes its column and raises not_positive_definite on
// every result of that matrix. Order 0 acts as 1 and an order above
// MAX_ORDER acts as MAX_ORDER. The store reads as zero after reset, with no
// clearing pass.
module cholesky_factorization
  import chol_pkg::*;
#(
  parameter int MAX_ORDER = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [3:0]              cfg_order,
  // load channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [IDX_W-1:0]        row,
  input  wire logic [IDX_W-1:0]        col,
  input  wire logic signed [VAL_W-1:0] value,
  input  wire logic                    last,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [IDX_W-1:0]             out_row,
  output logic [IDX_W-1:0]             out_col,
  output logic signed [VAL_W-1:0]      out_value,
  output logic                         out_last,
  output logic                         not_positive_definite
);

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    addr_of = AW'(int'(r) * MAX_ORDER + int'(c));
  endfunction

  chol_state_t state, state_next;

  logic [3:0]              order;
  logic [3:0]              n;
  logic [IDX_W-1:0]        i, j, k;
  logic [IDX_W-1:0]        er, ec;
  logic signed [VAL_W-1:0] acc;
  logic signed [VAL_W-1:0] opa;
  logic signed [63:0]      prod;
  logic signed [VAL_W-1:0] res;
  logic [ROOT_W-1:0]       root;
  logic                    zcol;
  logic                    pivot_err;

  logic                    in_xfer;
  logic                    out_xfer;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [VAL_W-1:0]        wdata;
  logic [AW-1:0]           raddr;
  logic [VAL_W-1:0]        rdata;
  sd_cmd_t                 sd_cmd;
  logic                    sd_busy;
  logic                    sd_done;
  logic signed [VAL_W-1:0] sd_res;

  logic                    row_end;
  logic                    col_end;
  logic                    k_end;
  logic                    em_col_end;
  logic                    em_row_end;
  logic signed [63:0]      rnd;
  logic signed [63:0]      diff;
  logic [3:0]              n_clamp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  assign row_end    = ({1'b0, i} + 4'd1) == n;
  assign col_end    = ({1'b0, j} + 4'd1) == n;
  assign k_end      = (k + 3'd1) == j;
  assign em_col_end = ({1'b0, ec} + 4'd1) == n;
  assign em_row_end = ({1'b0, er} + 4'd1) == n;

  // product rounded half up to Q16.16, then saturating subtract
  assign rnd  = (prod + 64'sd32768) >>> FRAC_W;
  assign diff = 64'(acc) - rnd;

  always_comb begin
    if (order == 4'd0) begin
      n_clamp = 4'd1;
    end else if (order > 4'(MAX_ORDER)) begin
      n_clamp = 4'(MAX_ORDER);
    end else begin
      n_clamp = order;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_xfer && last) state_next = S_RD;
      S_RD:    state_next = (zcol && (i != j)) ? S_WR : S_ACC;
      S_ACC:   state_next = (j != '0) ? S_OPA : S_FIN;
      S_OPA:   state_next = S_MUL;
      S_MUL:   state_next = S_SUB;
      S_SUB:   state_next = k_end ? S_FIN : S_OPA;
      S_FIN: begin
        if (i == j) begin
          state_next = (acc <= 0) ? S_WR : S_SQRT;
        end else begin
          state_next = S_DIV;
        end
      end
      S_SQRT:  if (sd_done) state_next = S_WR;
      S_DIV:   if (sd_done) state_next = S_WR;
      S_WR: begin
        if (row_end && col_end) begin
          state_next = S_EM_RD;
        end else begin
          state_next = S_RD;
        end
      end
      S_EM_RD: if (!out_valid) state_next = S_EM_LD;
      S_EM_LD: state_next = (em_row_end && em_col_end) ? S_IDLE : S_EM_RD;
      default: state_next = S_IDLE;
    endcase
  end

  // store and arithmetic unit controls
  always_comb begin
    we        = 1'b0;
    waddr     = addr_of(row, col);
    wdata     = value;
    raddr     = addr_of(i, j);
    sd_cmd    = '{start: 1'b0, op: SD_SQRT};
    unique case (state)
      S_IDLE: begin
        we = in_xfer && (int'(row) < MAX_ORDER) && (int'(col) < MAX_ORDER);
      end
      S_RD:    raddr = addr_of(i, j);
      S_ACC:   raddr = addr_of(j, '0);
      S_OPA:   raddr = addr_of(i, k);
      S_SUB:   raddr = addr_of(j, k + 3'd1);
      S_FIN: begin
        if (i == j) begin
          sd_cmd = '{start: (acc > 0), op: SD_SQRT};
        end else begin
          sd_cmd = '{start: 1'b1, op: SD_DIV};
        end
      end
      S_WR: begin
        we    = 1'b1;
        waddr = addr_of(i, j);
        wdata = res;
      end
      S_EM_RD: raddr = addr_of(er, ec);
      default: raddr = addr_of(i, j);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      order     <= 4'd8;
      pivot_err <= 1'b0;
      out_valid <= 1'b0;
      n         <= 4'(MAX_ORDER);
      i         <= '0;
      j         <= '0;
      k         <= '0;
      er        <= '0;
      ec        <= '0;
      zcol      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        order <= cfg_order;
      end
      if (out_xfer) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && last) begin
            n         <= n_clamp;
            i         <= '0;
            j         <= '0;
            zcol      <= 1'b0;
            pivot_err <= 1'b0;
          end
        end
        S_ACC:   k <= '0;
        S_SUB:   k <= k + 3'd1;
        S_FIN: begin
          if ((i == j) && (acc <= 0)) begin
            pivot_err <= 1'b1;
            zcol      <= 1'b1;
          end
        end
        S_WR: begin
          if (!row_end) begin
            i <= i + 3'd1;
          end else if (!col_end) begin
            j    <= j + 3'd1;
            i    <= j + 3'd1;
            zcol <= 1'b0;
          end else begin
            er <= '0;
            ec <= '0;
          end
        end
        S_EM_LD: begin
          out_valid <= 1'b1;
          if (em_col_end) begin
            ec <= '0;
            er <= er + 3'd1;
          end else begin
            ec <= ec + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_RD:   res <= '0;
      S_ACC:  acc <= rdata;
      S_OPA:  opa <= rdata;
      S_MUL:  prod <= 64'(opa) * 64'($signed(rdata));
      S_SUB:  acc <= sat_val(diff);
      S_FIN:  res <= '0;
      S_SQRT: begin
        if (sd_done) begin
          res  <= sd_res;
          root <= sd_res[ROOT_W-1:0];
        end
      end
      S_DIV:  if (sd_done) res <= sd_res;
      S_EM_LD: begin
        out_row               <= er;
        out_col               <= ec;
        out_value             <= (ec > er) ? '0 : rdata;
        out_last              <= em_row_end && em_col_end;
        not_positive_definite <= pivot_err;
      end
      default: ;
    endcase
  end

  chol_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  chol_sqdiv u_sqdiv (
    .clk     (clk),
    .rst     (rst),
    .cmd     (sd_cmd),
    .opnd    (acc),
    .divisor (root),
    .busy    (sd_busy),
    .done    (sd_done),
    .result  (sd_res)
  );

  // a result only appears from the emission step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EM_LD))
    else $error("result raised outside emission");

  // the serial unit is never restarted mid-operation
  a_sd_idle: assert property (@(posedge clk) disable iff (rst)
    sd_cmd.start |-> !sd_busy)
    else $error("square root / divide started while busy");

  // factor writes stay on or below the diagonal
  a_lower: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (i >= j))
    else $error("write above diagonal");

  // the pivot flag is raised only when a pivot is judged
  a_pivot: assert property (@(posedge clk) disable iff (rst)
    $rose(pivot_err) |-> $past(state == S_FIN))
    else $error("pivot flag set outside pivot check");

endmodule
`default_nettype wire
